// File: rtl/utf8_stream_decoder_assert.svh
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, held off while in reset
`define UTF8SD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("utf8 decoder check failed");
// clocked check, active during reset as well
`define UTF8SD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("utf8 decoder check failed");
`else
`define UTF8SD_ASSERT(label, clk, rst, prop)
`define UTF8SD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/utf8sd_pkg.sv
package utf8sd_pkg;

  // field widths of a request and a result
  localparam int BYTE_W = 8;
  localparam int CP_W   = 32;
  localparam int LEN_W  = 3;
  localparam int OUT_W  = 40;
  localparam int PAD_W  = OUT_W - CP_W - LEN_W - 1;

  // continuation byte recognition
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PREFIX  = 8'h80;
  localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;
  localparam logic [BYTE_W-1:0] ALL_ONES     = 8'hFF;

  // leading one counts with special meaning
  localparam logic [3:0] LEAD_PLAIN = 4'd0;
  localparam logic [3:0] LEAD_SOLO  = 4'd1;
  localparam logic [3:0] LEAD_FULL  = 4'd8;

  // one decoded character
  typedef struct packed {
    logic             bad_continuation;
    logic [LEN_W-1:0] seq_length;
    logic [CP_W-1:0]  code_point;
  } result_t;

endpackage

// File: rtl/utf8_stream_decoder.sv
// utf8 stream decoder: one byte per request, one code point per character
// a result is shown in the cycle after its last byte is accepted
// throughput: one byte per cycle; the single result register sets the rate,
// and a new byte is taken whenever that register is empty or being drained
// reset (rst, synchronous, active high) returns to idle and drops any result
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder #(
  parameter int CODE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] code_point, [34:32] seq_length,
                                     // [35] bad_continuation, [39:36] zero
);

  // decoder state
  logic [2:0]            remaining;
  logic [2:0]            remaining_next;
  logic [CODE_WIDTH-1:0] acc;
  logic [CODE_WIDTH-1:0] acc_next;
  logic [2:0]            seq_len;
  logic [2:0]            seq_len_next;
  logic                  err;
  logic                  err_next;

  // result register
  logic                  out_valid;
  utf8sd_pkg::result_t   out_res;
  utf8sd_pkg::result_t   res_next;
  logic                  emit;

  logic                  accept;
  logic [3:0]            lead_ones;
  logic [7:0]            lead_bits;
  logic [CODE_WIDTH+31:0] acc_wide;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // count of leading one bits of the byte
  always_comb begin
    if (!s_axis_tdata[7]) begin
      lead_ones = 4'd0;
    end else if (!s_axis_tdata[6]) begin
      lead_ones = 4'd1;
    end else if (!s_axis_tdata[5]) begin
      lead_ones = 4'd2;
    end else if (!s_axis_tdata[4]) begin
      lead_ones = 4'd3;
    end else if (!s_axis_tdata[3]) begin
      lead_ones = 4'd4;
    end else if (!s_axis_tdata[2]) begin
      lead_ones = 4'd5;
    end else if (!s_axis_tdata[1]) begin
      lead_ones = 4'd6;
    end else if (!s_axis_tdata[0]) begin
      lead_ones = 4'd7;
    end else begin
      lead_ones = 4'd8;
    end
  end

  // bits of a lead byte below its length prefix
  assign lead_bits = s_axis_tdata & (utf8sd_pkg::ALL_ONES >> lead_ones);

  // next state and result for the byte on the input
  always_comb begin
    remaining_next = remaining;
    acc_next       = acc;
    seq_len_next   = seq_len;
    err_next       = err;
    emit           = 1'b0;
    res_next.code_point       = '0;
    res_next.seq_length       = 3'd1;
    res_next.bad_continuation = 1'b0;
    acc_wide = '0;

    if (remaining == 3'd0) begin
      if (lead_ones == utf8sd_pkg::LEAD_PLAIN || lead_ones == utf8sd_pkg::LEAD_FULL) begin
        // plain character, state untouched
        emit = 1'b1;
        res_next.code_point = {24'd0, s_axis_tdata};
      end else begin
        acc_next     = {{(CODE_WIDTH-8){1'b0}}, lead_bits};
        seq_len_next = lead_ones[2:0];
        err_next     = 1'b0;
        if (lead_ones == utf8sd_pkg::LEAD_SOLO) begin
          // stray continuation byte taken as a one byte sequence
          emit = 1'b1;
          res_next.code_point = {24'd0, lead_bits};
        end else begin
          remaining_next = lead_ones[2:0] - 3'd1;
        end
      end
    end else begin
      // following byte: append six bits, flag a bad prefix
      if ((s_axis_tdata & utf8sd_pkg::CONT_MASK) != utf8sd_pkg::CONT_PREFIX) begin
        err_next = 1'b1;
      end
      acc_next       = {acc[CODE_WIDTH-7:0], s_axis_tdata[5:0]};
      remaining_next = remaining - 3'd1;
      acc_wide       = {32'd0, acc_next};
      if (remaining_next == 3'd0) begin
        emit = 1'b1;
        res_next.code_point       = acc_wide[31:0];
        res_next.seq_length       = seq_len;
        res_next.bad_continuation = err_next;
      end
    end
  end

  // state update on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 3'd0;
      acc       <= '0;
      seq_len   <= 3'd0;
      err       <= 1'b0;
    end else if (accept) begin
      remaining <= remaining_next;
      acc       <= acc_next;
      seq_len   <= seq_len_next;
      err       <= err_next;
    end
  end

  // result register and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{utf8sd_pkg::PAD_W{1'b0}}, out_res};

  // a stalled input only ever means a result is waiting
  `UTF8SD_ASSERT(a_stall_has_result, clk, rst, !s_axis_tready |-> m_axis_tvalid)
  // mid sequence the length is multi byte and ahead of the count
  `UTF8SD_ASSERT(a_len_ahead, clk, rst, remaining != 3'd0 |-> (seq_len >= 3'd2 && remaining < seq_len))
  // the closing byte of a sequence yields a result next cycle
  `UTF8SD_ASSERT(a_close_emits, clk, rst, (accept && remaining == 3'd1) |=> m_axis_tvalid)
  // a single byte character never carries a continuation error
  `UTF8SD_ASSERT(a_single_clean, clk, rst, (m_axis_tvalid && m_axis_tdata[34:32] == 3'd1) |-> !m_axis_tdata[35])

endmodule
